// ----- hdl/gwt_pkg.sv -----
package gwt_pkg;

  localparam int unsigned WSUM_W = 32;
  localparam int unsigned MSUM_W = 40;
  localparam int unsigned DVD_W  = MSUM_W + 8;
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned STEP_W = 3;

  localparam logic [15:0]       DEFAULT_Q8 = 16'd32640;
  localparam logic [15:0]       THRESH_MAX = 16'd65280;
  localparam logic [CNT_W-1:0]  DIV_LAST   = CNT_W'(DVD_W - 1);

  typedef struct packed {
    logic [7:0] gray_level;
    logic [7:0] local_mean;
    logic       frame_end;
  } gwt_in_t;

  typedef struct packed {
    logic [15:0] threshold_q8;
    logic        used_default;
  } gwt_out_t;

  typedef enum logic [2:0] {
    COND_FRAME_END,
    COND_WSUM_ZERO,
    COND_CNT_DONE,
    COND_OUT_FREE
  } cond_t;

  typedef enum logic [STEP_W-1:0] {
    STEP_WAIT    = 3'd0,
    STEP_CHECK   = 3'd1,
    STEP_DIV     = 3'd2,
    STEP_CLAMP   = 3'd3,
    STEP_DEFAULT = 3'd4
  } step_t;

  typedef struct packed {
    logic  take_pixel;
    logic  load_div;
    logic  div_step;
    logic  write_out;
    logic  sel_default;
    cond_t cond;
    step_t tgt_true;
    step_t tgt_false;
  } ucode_t;

  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    w = '{take_pixel: 1'b0, load_div: 1'b0, div_step: 1'b0, write_out: 1'b0,
          sel_default: 1'b0, cond: COND_FRAME_END, tgt_true: STEP_WAIT,
          tgt_false: STEP_WAIT};
    case (step)
      STEP_WAIT: begin
        w.take_pixel = 1'b1;
        w.cond       = COND_FRAME_END;
        w.tgt_true   = STEP_CHECK;
        w.tgt_false  = STEP_WAIT;
      end
      STEP_CHECK: begin
        w.load_div  = 1'b1;
        w.cond      = COND_WSUM_ZERO;
        w.tgt_true  = STEP_DEFAULT;
        w.tgt_false = STEP_DIV;
      end
      STEP_DIV: begin
        w.div_step  = 1'b1;
        w.cond      = COND_CNT_DONE;
        w.tgt_true  = STEP_CLAMP;
        w.tgt_false = STEP_DIV;
      end
      STEP_CLAMP: begin
        w.write_out = 1'b1;
        w.cond      = COND_OUT_FREE;
        w.tgt_true  = STEP_WAIT;
        w.tgt_false = STEP_CLAMP;
      end
      STEP_DEFAULT: begin
        w.write_out   = 1'b1;
        w.sel_default = 1'b1;
        w.cond        = COND_OUT_FREE;
        w.tgt_true    = STEP_WAIT;
        w.tgt_false   = STEP_DEFAULT;
      end
      default: begin
        w.tgt_true  = STEP_WAIT;
        w.tgt_false = STEP_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/gradient_weighted_threshold.sv -----
// Latency: a pixel beat is absorbed into the accumulators in the cycle it is accepted.
// Throughput: one pixel beat per cycle while no frame end is in progress.
// Frame end: result registered after the zero check, the 48-step restoring divider and
//   the clamp; the weight-zero case goes from the zero check to the default. No beat is taken meanwhile.
// The result waits in an output register; pixels of the next frame are taken meanwhile.
// Reset (rst_n low, synchronous) clears the accumulators, the step register and out_valid.
module gradient_weighted_threshold
  import gwt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  gwt_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output gwt_out_t out_data
);

  step_t              step_r, step_nxt;
  logic [WSUM_W-1:0]  wsum_r, wsum_nxt;
  logic [MSUM_W-1:0]  msum_r, msum_nxt;
  logic [DVD_W-1:0]   dvd_r, dvd_nxt;
  logic [WSUM_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  gwt_out_t           out_data_r, out_data_nxt;

  ucode_t             uw;
  logic               cond_hit;
  logic               out_free;
  logic               accept;
  logic [7:0]         weight;
  logic [15:0]        prod;
  logic [WSUM_W:0]    ws_sum;
  logic [MSUM_W:0]    ms_sum;
  logic [WSUM_W:0]    rem_sh;
  logic [WSUM_W:0]    rem_sub;
  logic               qbit;
  logic               q_over;

  assign uw       = ucode_rom(step_r);
  assign in_stall = ~uw.take_pixel;
  assign accept   = in_valid & uw.take_pixel;
  assign out_free = ~out_valid_r | ~out_stall;

  always_comb begin
    case (uw.cond)
      COND_FRAME_END: cond_hit = accept & in_data.frame_end;
      COND_WSUM_ZERO: cond_hit = (wsum_r == '0);
      COND_CNT_DONE:  cond_hit = (cnt_r == '0);
      COND_OUT_FREE:  cond_hit = out_free;
      default:        cond_hit = 1'b0;
    endcase
    step_nxt = cond_hit ? uw.tgt_true : uw.tgt_false;
  end

  assign weight = (in_data.gray_level >= in_data.local_mean) ?
                  (in_data.gray_level - in_data.local_mean) :
                  (in_data.local_mean - in_data.gray_level);
  assign prod   = 16'(weight) * 16'(in_data.local_mean);
  assign ws_sum = {1'b0, wsum_r} + (WSUM_W + 1)'(weight);
  assign ms_sum = {1'b0, msum_r} + (MSUM_W + 1)'(prod);

  assign rem_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, wsum_r};
  assign qbit    = ~rem_sub[WSUM_W];
  assign q_over  = (dvd_r[DVD_W-1:16] != '0) || (dvd_r[15:0] > THRESH_MAX);

  always_comb begin
    wsum_nxt      = wsum_r;
    msum_nxt      = msum_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r & out_stall;
    if (accept) begin
      wsum_nxt = ws_sum[WSUM_W] ? '1 : ws_sum[WSUM_W-1:0];
      msum_nxt = ms_sum[MSUM_W] ? '1 : ms_sum[MSUM_W-1:0];
    end
    if (uw.load_div) begin
      dvd_nxt = {msum_r, 8'd0};
      rem_nxt = '0;
      cnt_nxt = DIV_LAST;
    end
    if (uw.div_step) begin
      rem_nxt = qbit ? rem_sub[WSUM_W-1:0] : rem_sh[WSUM_W-1:0];
      dvd_nxt = {dvd_r[DVD_W-2:0], qbit};
      cnt_nxt = cnt_r - CNT_W'(1);
    end
    if (uw.write_out && out_free) begin
      out_valid_nxt = 1'b1;
      wsum_nxt      = '0;
      msum_nxt      = '0;
      if (uw.sel_default) begin
        out_data_nxt.threshold_q8 = DEFAULT_Q8;
        out_data_nxt.used_default = 1'b1;
      end else begin
        out_data_nxt.threshold_q8 = q_over ? THRESH_MAX : dvd_r[15:0];
        out_data_nxt.used_default = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_WAIT;
      wsum_r      <= '0;
      msum_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      wsum_r      <= wsum_nxt;
      msum_r      <= msum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
